[sv/factorial_prime_factorizer_unit_macros.svh]
// Assertion macros for the factorial prime factoriser unit.
`ifndef FACTORIAL_PRIME_FACTORIZER_UNIT_MACROS_SVH
`define FACTORIAL_PRIME_FACTORIZER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off during rst.
`define FPF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpf assertion failed");
// Next-cycle implication, sampled on clk, off during rst.
`define FPF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpf assertion failed");
`else
`define FPF_ASSERT_IMPL(label, ante, cons)
`define FPF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[sv/fpf_pkg.sv]
// Shared types and constants for the factorial prime factoriser.
`timescale 1ns / 1ps

package fpf_pkg;

  localparam int AddrW = 8;
  localparam int Depth = 1 << AddrW;
  localparam int DataW = 8;
  localparam logic [DataW-1:0] CountMax = '1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SV_CHK,
    ST_SV_RD,
    ST_SV_MARK,
    ST_FAC_I,
    ST_FAC_P,
    ST_FAC_FLAG,
    ST_FAC_DIV,
    ST_FAC_CNT,
    ST_EM_RD,
    ST_EM_CHK,
    ST_EM_LAST
  } fsm_state_t;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic             flag_we;
    logic             flag_wd;
    logic             cnt_we;
    logic [DataW-1:0] cnt_wd;
  } store_req_t;

  typedef struct packed {
    logic             flag;
    logic [DataW-1:0] count;
  } store_rsp_t;

  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quotient;
    logic [DataW-1:0] remainder;
  } div_rsp_t;

  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] prime;
    logic [DataW-1:0] exponent;
    logic             last;
  } result_t;

endpackage

[sv/fpf_div.sv]
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module fpf_div import fpf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CntW = $clog2(DataW);

  logic            running;
  logic            done;
  logic [CntW-1:0] bit_cnt;
  logic [DataW-1:0] rem;
  logic [DataW-1:0] quo;
  logic [DataW-1:0] dvsr;

  logic [DataW:0] shifted;
  logic [DataW:0] diff;
  logic           ge;

  // trial subtract of the divisor from the shifted partial remainder
  assign shifted = {rem, quo[DataW-1]};
  assign diff    = shifted - {1'b0, dvsr};
  assign ge      = shifted >= {1'b0, dvsr};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      bit_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        bit_cnt <= '0;
      end else if (running) begin
        bit_cnt <= bit_cnt + 1'b1;
        if (bit_cnt == CntW'(DataW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // datapath: quo starts as the dividend and fills with quotient bits
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      quo  <= req.dividend;
      dvsr <= req.divisor;
    end else if (running) begin
      rem <= ge ? diff[DataW-1:0] : shifted[DataW-1:0];
      quo <= {quo[DataW-2:0], ge};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

[sv/fpf_store.sv]
// Prime flag and exponent count memories, one synchronous port each.
`timescale 1ns / 1ps

module fpf_store import fpf_pkg::*; (
  input  logic       clk,
  input  store_req_t req,
  output store_rsp_t rsp
);

  logic             flag_mem [Depth];
  logic [DataW-1:0] cnt_mem  [Depth];

  // flag and count stores: read data registered, old value on a write
  always_ff @(posedge clk) begin
    if (req.flag_we) begin
      flag_mem[req.addr] <= req.flag_wd;
    end
    if (req.cnt_we) begin
      cnt_mem[req.addr] <= req.cnt_wd;
    end
    rsp.flag  <= flag_mem[req.addr];
    rsp.count <= cnt_mem[req.addr];
  end

endmodule

[sv/fpf_seq.sv]
// Sequencer: clears, sieves, trial-divides and reports the factor list.
`timescale 1ns / 1ps

module fpf_seq import fpf_pkg::*; #(
  parameter int MAX_N = 255
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DataW-1:0] n_value,
  output logic             busy,
  output store_req_t       st_req,
  input  store_rsp_t       st_rsp,
  output div_req_t         dv_req,
  input  div_rsp_t         dv_rsp,
  output result_t          res
);

  localparam int CapN = (MAX_N > Depth - 1) ? Depth - 1 : MAX_N;
  localparam logic [DataW-1:0] CapVal = CapN[DataW-1:0];
  localparam int SvW = 5;

  fsm_state_t state, state_next;

  logic [DataW-1:0] n_lim, n_lim_next;
  logic [DataW:0]   p, p_next;
  logic [SvW-1:0]   sv_i, sv_i_next;
  logic [DataW:0]   sv_j, sv_j_next;
  logic [DataW-1:0] fi, fi_next;
  logic [DataW-1:0] q, q_next;
  logic [DataW-1:0] pend_prime, pend_prime_next;
  logic [DataW-1:0] pend_exp, pend_exp_next;
  logic             have_pend, have_pend_next;

  logic [DataW-1:0]   n_eff;
  logic [2*SvW-1:0]   sv_sq;

  assign n_eff = (n_value > CapVal) ? CapVal : n_value;
  assign sv_sq = (2*SvW)'(sv_i) * (2*SvW)'(sv_i);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    n_lim      <= n_lim_next;
    p          <= p_next;
    sv_i       <= sv_i_next;
    sv_j       <= sv_j_next;
    fi         <= fi_next;
    q          <= q_next;
    pend_prime <= pend_prime_next;
    pend_exp   <= pend_exp_next;
    have_pend  <= have_pend_next;
  end

  // next state and outputs
  always_comb begin
    state_next      = state;
    n_lim_next      = n_lim;
    p_next          = p;
    sv_i_next       = sv_i;
    sv_j_next       = sv_j;
    fi_next         = fi;
    q_next          = q;
    pend_prime_next = pend_prime;
    pend_exp_next   = pend_exp;
    have_pend_next  = have_pend;

    st_req      = '0;
    st_req.addr = p[AddrW-1:0];
    dv_req      = '0;
    res         = '0;
    busy        = (state != ST_IDLE);

    case (state)
      ST_IDLE: begin
        if (start) begin
          if (n_eff < DataW'(2)) begin
            // no primes: a single empty item
            res.valid = 1'b1;
            res.last  = 1'b1;
          end else begin
            n_lim_next = n_eff;
            p_next     = '0;
            state_next = ST_INIT;
          end
        end
      end

      // set flags 0..n (entries from 2 up marked prime), zero their counts
      ST_INIT: begin
        st_req.flag_we = 1'b1;
        st_req.flag_wd = (p >= (DataW + 1)'(2));
        st_req.cnt_we  = 1'b1;
        if (p[DataW-1:0] == n_lim) begin
          sv_i_next  = SvW'(2);
          state_next = ST_SV_CHK;
        end else begin
          p_next = p + 1'b1;
        end
      end

      // sieve outer loop while i*i <= n
      ST_SV_CHK: begin
        if (sv_sq > (2*SvW)'(n_lim)) begin
          fi_next    = DataW'(2);
          state_next = ST_FAC_I;
        end else begin
          st_req.addr = AddrW'(sv_i);
          state_next  = ST_SV_RD;
        end
      end

      ST_SV_RD: begin
        if (st_rsp.flag) begin
          sv_j_next  = sv_sq[DataW:0];
          state_next = ST_SV_MARK;
        end else begin
          sv_i_next  = sv_i + 1'b1;
          state_next = ST_SV_CHK;
        end
      end

      // strike multiples of i
      ST_SV_MARK: begin
        if (sv_j > {1'b0, n_lim}) begin
          sv_i_next  = sv_i + 1'b1;
          state_next = ST_SV_CHK;
        end else begin
          st_req.addr    = sv_j[AddrW-1:0];
          st_req.flag_we = 1'b1;
          st_req.flag_wd = 1'b0;
          sv_j_next      = sv_j + (DataW + 1)'(sv_i);
        end
      end

      ST_FAC_I: begin
        q_next     = fi;
        p_next     = (DataW + 1)'(2);
        state_next = ST_FAC_P;
      end

      // no prime above the quotient can divide it
      ST_FAC_P: begin
        if (p > {1'b0, q}) begin
          if (fi == n_lim) begin
            p_next         = (DataW + 1)'(2);
            have_pend_next = 1'b0;
            state_next     = ST_EM_RD;
          end else begin
            fi_next    = fi + 1'b1;
            state_next = ST_FAC_I;
          end
        end else begin
          state_next = ST_FAC_FLAG;
        end
      end

      ST_FAC_FLAG: begin
        if (st_rsp.flag) begin
          dv_req.start    = 1'b1;
          dv_req.dividend = q;
          dv_req.divisor  = p[DataW-1:0];
          state_next      = ST_FAC_DIV;
        end else begin
          p_next     = p + 1'b1;
          state_next = ST_FAC_P;
        end
      end

      // count read is issued on the done cycle, address held at p
      ST_FAC_DIV: begin
        if (dv_rsp.done) begin
          if (dv_rsp.remainder == '0) begin
            q_next     = dv_rsp.quotient;
            state_next = ST_FAC_CNT;
          end else begin
            p_next     = p + 1'b1;
            state_next = ST_FAC_P;
          end
        end
      end

      // saturating count write-back, then try the same prime again
      ST_FAC_CNT: begin
        st_req.cnt_we   = 1'b1;
        st_req.cnt_wd   = (st_rsp.count == CountMax) ? st_rsp.count
                                                     : st_rsp.count + 1'b1;
        dv_req.start    = 1'b1;
        dv_req.dividend = q;
        dv_req.divisor  = p[DataW-1:0];
        state_next      = ST_FAC_DIV;
      end

      ST_EM_RD: begin
        if (p > {1'b0, n_lim}) begin
          state_next = ST_EM_LAST;
        end else begin
          state_next = ST_EM_CHK;
        end
      end

      // one item held back so the final one can carry last
      ST_EM_CHK: begin
        if (st_rsp.flag) begin
          if (have_pend) begin
            res.valid    = 1'b1;
            res.prime    = pend_prime;
            res.exponent = pend_exp;
          end
          pend_prime_next = p[DataW-1:0];
          pend_exp_next   = st_rsp.count;
          have_pend_next  = 1'b1;
        end
        p_next     = p + 1'b1;
        state_next = ST_EM_RD;
      end

      ST_EM_LAST: begin
        res.valid    = 1'b1;
        res.prime    = pend_prime;
        res.exponent = pend_exp;
        res.last     = 1'b1;
        state_next   = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[sv/factorial_prime_factorizer_unit.sv]
// Top level of the factorial prime factoriser.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------
//   request  | start, busy          | n_value
//   result   | valid (1-cycle pulse)| prime, exponent, last
//
// n below 2 gives one empty item in the cycle after the request; busy stays low.
// Otherwise busy rises for the clear pass over entries 0..n, the sieve, the trial
// division and the report pass. A prime tried takes a flag read, a divider start,
// the divider steps and a result check; an exact division adds a count write-back
// and a new division; a composite is skipped after its flag read. rst is synchronous;
// entries 0..n are rewritten per request, so no clearing. Results cannot be stalled.
`timescale 1ns / 1ps
`include "factorial_prime_factorizer_unit_macros.svh"

module factorial_prime_factorizer_unit import fpf_pkg::*; #(
  parameter int MAX_N = 255
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [DataW-1:0] n_value,
  output logic             valid,
  output logic [DataW-1:0] prime,
  output logic [DataW-1:0] exponent,
  output logic             last
);

  store_req_t st_req;
  store_rsp_t st_rsp;
  div_req_t   dv_req;
  div_rsp_t   dv_rsp;
  result_t    res;

  fpf_seq #(
    .MAX_N(MAX_N)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .n_value(n_value),
    .busy   (busy),
    .st_req (st_req),
    .st_rsp (st_rsp),
    .dv_req (dv_req),
    .dv_rsp (dv_rsp),
    .res    (res)
  );

  fpf_store u_store (
    .clk(clk),
    .req(st_req),
    .rsp(st_rsp)
  );

  fpf_div u_div (
    .clk(clk),
    .rst(rst),
    .req(dv_req),
    .rsp(dv_rsp)
  );

  // result register: strobe cleared by reset, payload free-running
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    prime    <= res.prime;
    exponent <= res.exponent;
    last     <= res.last;
  end

  // checks
  `FPF_ASSERT_NEXT(a_big_n_busy, start && !busy && (n_value >= 8'd2), busy)
  `FPF_ASSERT_NEXT(a_small_n_empty, start && !busy && (n_value < 8'd2),
                   valid && last && (prime == 8'd0) && (exponent == 8'd0))
  `FPF_ASSERT_IMPL(a_empty_is_last, valid && (prime == 8'd0), last)
  `FPF_ASSERT_IMPL(a_more_to_come, valid && !last, busy)

endmodule

[tb/tb_factorial_prime_factorizer_unit.sv]
// Self-checking testbench for the factorial prime factoriser unit.
`timescale 1ns / 1ps

module tb_factorial_prime_factorizer_unit import fpf_pkg::*; ();

  localparam int MaxN = 255;
  localparam int ResetCycles = 4;
  localparam int SettleCycles = 64;
  localparam int RandomRequests = 100;
  localparam int DirectedRows = 22;

  // One factor item as the block reports it
  typedef struct packed {
    logic [DataW-1:0] prime;
    logic [DataW-1:0] exponent;
    logic             last;
  } factor_t;

  // Directed row: typed rows carry their single expected factor item
  typedef struct packed {
    logic [DataW-1:0] n;
    logic             typed;
    factor_t          want;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [DataW-1:0] n_value = '0;
  logic             busy;
  logic             valid;
  logic [DataW-1:0] prime;
  logic [DataW-1:0] exponent;
  logic             last;

  factor_t         expected_factors [$];
  factor_t         oldest_factor;
  int unsigned     error_count = 0;
  longint unsigned cycle_count = 0;
  longint unsigned cycle_budget = 10000;

  localparam factor_t EmptyFactor = '{prime: '0, exponent: '0, last: 1'b1};
  localparam factor_t NoFactor = '{prime: '0, exponent: '0, last: 1'b0};
  localparam factor_t TwoOnly = '{prime: 8'd2, exponent: 8'd1, last: 1'b1};

  stim_row_t directed_rows [DirectedRows] = '{
    '{n: 8'd0,   typed: 1'b1, want: EmptyFactor},
    '{n: 8'd1,   typed: 1'b1, want: EmptyFactor},
    '{n: 8'd2,   typed: 1'b1, want: TwoOnly},
    '{n: 8'd3,   typed: 1'b0, want: NoFactor},
    '{n: 8'd4,   typed: 1'b0, want: NoFactor},
    '{n: 8'd5,   typed: 1'b0, want: NoFactor},
    '{n: 8'd255, typed: 1'b0, want: NoFactor},
    '{n: 8'd0,   typed: 1'b1, want: EmptyFactor},
    '{n: 8'd254, typed: 1'b0, want: NoFactor},
    '{n: 8'd1,   typed: 1'b1, want: EmptyFactor},
    '{n: 8'd128, typed: 1'b0, want: NoFactor},
    '{n: 8'd127, typed: 1'b0, want: NoFactor},
    '{n: 8'd6,   typed: 1'b0, want: NoFactor},
    '{n: 8'd7,   typed: 1'b0, want: NoFactor},
    '{n: 8'd8,   typed: 1'b0, want: NoFactor},
    '{n: 8'd16,  typed: 1'b0, want: NoFactor},
    '{n: 8'd31,  typed: 1'b0, want: NoFactor},
    '{n: 8'd32,  typed: 1'b0, want: NoFactor},
    '{n: 8'd64,  typed: 1'b0, want: NoFactor},
    '{n: 8'd100, typed: 1'b0, want: NoFactor},
    '{n: 8'd170, typed: 1'b0, want: NoFactor},
    '{n: 8'd2,   typed: 1'b1, want: TwoOnly}
  };

  factorial_prime_factorizer_unit #(
    .MAX_N(MaxN)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .n_value (n_value),
    .valid   (valid),
    .prime   (prime),
    .exponent(exponent),
    .last    (last)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Append one expected factor item to the back of the scoreboard
  function automatic void queue_factor(input factor_t f);
    expected_factors.insert(expected_factors.size(), f);
  endfunction

  // Factorisation of n!: sieve, trial-divide 2..n, one item per prime in order
  function automatic void predict_factorization(input logic [DataW-1:0] n_in);
    int unsigned      n;
    int unsigned      i;
    int unsigned      j;
    int unsigned      p;
    int unsigned      top_prime;
    logic [DataW-1:0] quotient;
    bit               is_prime [Depth];
    logic [DataW-1:0] counts [Depth];
    factor_t          f;
    n = 32'(n_in);
    if (n > MaxN) n = MaxN;
    if (n > Depth - 1) n = Depth - 1;
    // small n: no primes, one empty item
    if (n < 2) begin
      queue_factor(EmptyFactor);
      return;
    end
    for (i = 0; i <= n; i++) begin
      is_prime[i] = (i >= 2);
      counts[i] = '0;
    end
    for (i = 2; i * i <= n; i++) begin
      if (is_prime[i]) begin
        for (j = i * i; j <= n; j += i) is_prime[j] = 1'b0;
      end
    end
    for (i = 2; i <= n; i++) begin
      quotient = i[DataW-1:0];
      for (p = 2; p <= n; p++) begin
        if (is_prime[p]) begin
          while (quotient != 0 && (quotient % p) == 0) begin
            // count saturates rather than wrapping
            if (counts[p] != CountMax) counts[p] = counts[p] + 1'b1;
            quotient = DataW'(quotient / p);
          end
        end
      end
    end
    top_prime = 0;
    for (p = 2; p <= n; p++) begin
      if (is_prime[p]) top_prime = p;
    end
    for (p = 2; p <= n; p++) begin
      if (is_prime[p]) begin
        f.prime = p[DataW-1:0];
        f.exponent = counts[p];
        f.last = (p == top_prime);
        queue_factor(f);
      end
    end
  endfunction

  // Issue one request, after a random gap unless no_idle is set, and record what it should produce
  task automatic send_request(input logic [DataW-1:0] n_in, input bit typed,
                              input factor_t want, input bit no_idle);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    n_value <= n_in;
    do @(posedge clk); while (busy);
    if (typed) queue_factor(want);
    else predict_factorization(n_in);
    // generous allowance: every prime tried on every integer, plus gaps and reports
    cycle_budget += 64 * (longint'(n_in) + 1) * (longint'(n_in) + 1) + 1000;
  endtask

  // Hold requests off until every expected factor item has come out
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (expected_factors.size() != 0);
  endtask

  // Result checker: the block cannot be stalled, so every pulse is consumed
  always @(posedge clk) begin
    if (!rst && valid) begin
      if (expected_factors.size() == 0) begin
        $error("unexpected result: prime %0d exponent %0d last %0b", prime, exponent, last);
        error_count++;
      end else begin
        oldest_factor = expected_factors.pop_front();
        if (prime !== oldest_factor.prime) begin
          $error("prime: expected %0d, got %0d", oldest_factor.prime, prime);
          error_count++;
        end
        if (exponent !== oldest_factor.exponent) begin
          $error("exponent: expected %0d, got %0d", oldest_factor.exponent, exponent);
          error_count++;
        end
        if (last !== oldest_factor.last) begin
          $error("last: expected %0b, got %0b", oldest_factor.last, last);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_budget) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int unsigned      k;
    int unsigned      sel;
    logic [DataW-1:0] n_rand;
    bit               no_idle;

    rst <= 1'b1;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    // directed rows, first few back to back
    for (k = 0; k < DirectedRows; k++) begin
      no_idle = (k < 4);
      send_request(directed_rows[k].n, directed_rows[k].typed, directed_rows[k].want,
                   no_idle);
    end

    // let the block empty out completely before the random part
    drain_results();
    repeat (SettleCycles) @(posedge clk);

    // random requests, mostly small n so the run stays short
    for (k = 0; k < RandomRequests; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) n_rand = DataW'($urandom_range(0, 1));
      else if (sel < 75) n_rand = DataW'($urandom_range(2, 31));
      else if (sel < 93) n_rand = DataW'($urandom_range(32, 96));
      else if (sel < 98) n_rand = DataW'($urandom_range(97, 254));
      else n_rand = 8'd255;
      // every third stretch of ten runs with no idling
      no_idle = ((k / 10) % 3 == 0);
      send_request(n_rand, 1'b0, NoFactor, no_idle);
      if ($urandom_range(0, 24) == 0) drain_results();
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk);

    if (expected_factors.size() != 0) begin
      $error("%0d expected factor items never arrived", expected_factors.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
